// File: src/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

    // Default number of heap entries
    localparam int CAPACITY = 16;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Request handed to the sift engine
    typedef struct packed {
        logic                     remove;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // Result handed back by the sift engine
    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] removed_value;
        logic [OCC_W-1:0]         occupancy;
    } res_t;

endpackage

// File: src/max_heap_priority_queue_core.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata                                     tuser
// s_axis   in   [31:0] item_value                         [0] req_type
// m_axis   out  [31:0] removed_value, [36:32] occupancy   [1:0] status
//
// One request at a time, one result each.
// Insert opens a hole at the end and moves parents down into it until the value fits.
// Remove reads the root and the last entry, then moves the larger child up each level.
// A dropped insert or an empty remove skips the RAM; one RAM read per cycle sets the cost.
// Reset clears the state and the entry count; the heap RAM needs no clearing pass.
// The output register frees the engine as soon as it holds the result.

module max_heap_priority_queue_core #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_value
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] occupancy, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int AW = $clog2(CAPACITY);

    mhpq_pkg::req_t                req;
    mhpq_pkg::res_t                res;
    logic                          res_valid;
    logic                          res_ready;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [mhpq_pkg::DATA_W-1:0]   wr_data;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [mhpq_pkg::DATA_W-1:0]   rd_data;

    logic                          m_valid_reg;
    mhpq_pkg::res_t                res_reg;

    assign req.remove = s_tuser;
    assign req.value  = $signed(s_tdata);

    mhpq_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    mhpq_ram #(
        .WIDTH (mhpq_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: load when empty or when the held result transfers
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_reg.occupancy, res_reg.removed_value};
    assign m_tuser  = res_reg.status;

endmodule

// File: src/mhpq_ram.sv
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/mhpq_engine.sv
`timescale 1ns / 1ps

module mhpq_engine #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request side
    input  logic                        req_valid,
    output logic                        req_ready,
    input  mhpq_pkg::req_t              req,
    // result side
    output logic                        res_valid,
    input  logic                        res_ready,
    output mhpq_pkg::res_t              res,
    // heap memory
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [mhpq_pkg::DATA_W-1:0] wr_data,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  logic [mhpq_pkg::DATA_W-1:0] rd_data
);

    localparam int LW = AW + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD_ROOT,
        ST_DN_RD_LAST,
        ST_DN_LOAD,
        ST_DN_RD_L,
        ST_DN_RD_R,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    state_t                             state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [AW-1:0]                      pos_reg, pos_next;
    logic signed [mhpq_pkg::DATA_W-1:0] val_reg, val_next;
    logic signed [mhpq_pkg::DATA_W-1:0] lval_reg, lval_next;
    logic                               has_r_reg, has_r_next;
    mhpq_pkg::status_t                  status_reg, status_next;
    logic signed [mhpq_pkg::DATA_W-1:0] removed_reg, removed_next;

    logic [LW-1:0]                      l_idx;
    logic [LW-1:0]                      r_idx;
    logic [AW-1:0]                      parent_idx;
    logic                               has_l;
    logic                               has_r;
    logic                               pick_r;
    logic signed [mhpq_pkg::DATA_W-1:0] best_val;
    logic [AW-1:0]                      best_idx;

    // Tree navigation around the hole position
    assign l_idx      = {pos_reg, 1'b1};
    assign r_idx      = l_idx + LW'(1);
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign has_l      = l_idx < LW'(count_reg);
    assign has_r      = r_idx < LW'(count_reg);

    // Larger child, left one on a tie
    assign pick_r   = has_r_reg && ($signed(rd_data) > lval_reg);
    assign best_val = pick_r ? $signed(rd_data) : lval_reg;
    assign best_idx = pick_r ? r_idx[AW-1:0] : l_idx[AW-1:0];

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    assign res.status        = status_reg;
    assign res.removed_value = removed_reg;
    assign res.occupancy     = mhpq_pkg::OCC_W'(count_reg);

    // Sequence the sift one level at a time through the memory
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        lval_next    = lval_reg;
        has_r_next   = has_r_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = val_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    removed_next = '0;
                    status_next  = mhpq_pkg::STAT_OK;
                    if (!req.remove)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            status_next = mhpq_pkg::STAT_FULL;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            pos_next   = AW'(count_reg);
                            val_next   = req.value;
                            count_next = count_reg + CW'(1);
                            state_next = ST_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = mhpq_pkg::STAT_EMPTY;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = ST_DN_RD_ROOT;
                        end
                    end
                end
            end

            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (val_reg > $signed(rd_data))
                begin
                    // move parent down into the hole
                    wr_data    = rd_data;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DN_RD_ROOT:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_DN_RD_LAST;
            end

            ST_DN_RD_LAST:
            begin
                removed_next = $signed(rd_data);
                rd_en        = 1'b1;
                rd_addr      = AW'(count_reg);
                state_next   = ST_DN_LOAD;
            end

            ST_DN_LOAD:
            begin
                val_next   = $signed(rd_data);
                pos_next   = '0;
                state_next = ST_DN_RD_L;
            end

            ST_DN_RD_L:
            begin
                if (!has_l)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = l_idx[AW-1:0];
                    state_next = ST_DN_RD_R;
                end
            end

            ST_DN_RD_R:
            begin
                lval_next  = $signed(rd_data);
                has_r_next = has_r;
                if (has_r)
                begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                end
                state_next = ST_DN_CMP;
            end

            ST_DN_CMP:
            begin
                wr_en = 1'b1;
                if (best_val > val_reg)
                begin
                    // move larger child up into the hole
                    wr_data    = best_val;
                    pos_next   = best_idx;
                    state_next = ST_DN_RD_L;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            status_reg <= mhpq_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        lval_reg    <= lval_next;
        has_r_reg   <= has_r_next;
        removed_reg <= removed_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("heap count above capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !wr_en)
        else $error("memory write outside a sift");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same entry");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && !req.remove && count_reg == CW'(CAPACITY))
        |=> (state_reg == ST_DONE && status_reg == mhpq_pkg::STAT_FULL
             && $stable(count_reg)))
        else $error("insert into full heap not dropped");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    // One request as the sender hands it over
    typedef struct {
        bit          remove;
        logic [31:0] value;
    } heap_request_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] item_value
    logic        s_tuser;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] removed_value, [36:32] occupancy, rest zero
    logic [1:0]  m_tuser;   // [1:0] status

    max_heap_priority_queue_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    heap_request_t      pending_reqs[$];
    mhpq_pkg::res_t     expected_results[$];
    logic signed [31:0] mirror_heap[mhpq_pkg::CAPACITY];
    int unsigned        mirror_count;
    int                 sender_idle_pct;
    int                 receiver_idle_pct;
    int                 pushed_cnt;
    int                 accepted_cnt;
    int                 error_count;
    int                 quiet_cycles;
    bit                 req_fired;

    always #10 clk = ~clk;

    // Apply one request to the mirror heap and return the result it should give
    function automatic mhpq_pkg::res_t predict_request(heap_request_t rq);
        mhpq_pkg::res_t     r;
        int unsigned        pos;
        int unsigned        up;
        int unsigned        lc;
        int unsigned        best;
        logic signed [31:0] tmp;
        bit                 done;
        r.status        = mhpq_pkg::STAT_OK;
        r.removed_value = '0;
        done            = 0;
        if (!rq.remove)
        begin
            if (mirror_count >= mhpq_pkg::CAPACITY)
            begin
                r.status = mhpq_pkg::STAT_FULL;
            end
            else
            begin
                // append, then sift up while strictly greater than the parent
                pos = mirror_count;
                mirror_heap[pos] = rq.value;
                mirror_count++;
                while (pos > 0 && !done)
                begin
                    up = (pos - 1) / 2;
                    if (mirror_heap[pos] > mirror_heap[up])
                    begin
                        tmp = mirror_heap[pos];
                        mirror_heap[pos] = mirror_heap[up];
                        mirror_heap[up] = tmp;
                        pos = up;
                    end
                    else
                    begin
                        done = 1;
                    end
                end
            end
        end
        else
        begin
            if (mirror_count == 0)
            begin
                r.status = mhpq_pkg::STAT_EMPTY;
            end
            else
            begin
                // take the root, move the last entry up and sift it down
                r.removed_value = mirror_heap[0];
                mirror_count--;
                mirror_heap[0] = mirror_heap[mirror_count];
                pos = 0;
                while (!done)
                begin
                    lc = 2 * pos + 1;
                    if (lc >= mirror_count)
                    begin
                        done = 1;
                    end
                    else
                    begin
                        best = lc;
                        if (lc + 1 < mirror_count && mirror_heap[lc + 1] > mirror_heap[lc])
                            best = lc + 1;
                        if (mirror_heap[best] > mirror_heap[pos])
                        begin
                            tmp = mirror_heap[pos];
                            mirror_heap[pos] = mirror_heap[best];
                            mirror_heap[best] = tmp;
                            pos = best;
                        end
                        else
                        begin
                            done = 1;
                        end
                    end
                end
            end
        end
        r.occupancy = mirror_count[mhpq_pkg::OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [39:0] want, logic [39:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endtask

    task automatic push_req(bit remove, logic [31:0] value);
        heap_request_t rq;
        rq.remove = remove;
        rq.value  = value;
        pending_reqs.push_back(rq);
        pushed_cnt++;
    endtask

    // Mostly full-range values, some clustered near zero for ties, some extremes
    function automatic logic [31:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return $urandom;
        if (sel < 85)
            return $urandom_range(8) - 4;
        case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Bursts of mostly inserts, mostly removes or an even mix; bursts run up to
    // 20 requests, more than the heap holds, so they can reach the full and the empty heap
    task automatic queue_random(int count);
        int left;
        int kind;
        int len;
        int remove_pct;
        left = count;
        while (left > 0)
        begin
            kind = $urandom_range(9);
            len  = $urandom_range(20, 1);
            if (len > left)
                len = left;
            remove_pct = (kind < 4) ? 15 : (kind < 7) ? 85 : 50;
            for (int i = 0; i < len; i++)
                push_req($urandom_range(99) < remove_pct, pick_value());
            left -= len;
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (accepted_cnt != pushed_cnt || expected_results.size() != 0);
    endtask

    // Drive the request side and the result-side ready at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || req_fired)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_reqs[0].value;
                    s_tuser  <= pending_reqs[0].remove;
                    void'(pending_reqs.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Check results, predict accepted requests and watch for a hang
    always @(posedge clk)
    begin
        mhpq_pkg::res_t want;
        heap_request_t  rq;
        req_fired = s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected transfer", 40'h0, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", want.status, m_tuser);
                    if (m_tdata[31:0] !== want.removed_value)
                        report_mismatch("removed_value", want.removed_value, m_tdata[31:0]);
                    if (m_tdata[36:32] !== want.occupancy)
                        report_mismatch("occupancy", want.occupancy, m_tdata[36:32]);
                    if (m_tdata[39:37] !== 3'b000)
                        report_mismatch("tdata padding", 40'h0, m_tdata[39:37]);
                end
            end
            if (req_fired)
            begin
                rq.remove = s_tuser;
                rq.value  = s_tdata;
                expected_results.push_back(predict_request(rq));
                accepted_cnt++;
            end
            if (req_fired || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        s_tuser           = 1'b0;
        m_tready          = 1'b0;
        mirror_count      = 0;
        pushed_cnt        = 0;
        accepted_cnt      = 0;
        error_count       = 0;
        quiet_cycles      = 0;
        req_fired         = 1'b0;
        sender_idle_pct   = 36;
        receiver_idle_pct = 56;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: remove on empty, extremes and ties rising to the root,
        // fill to capacity, insert on full, then take a few maxima out
        push_req(1'b1, 32'h1234_5678);
        push_req(1'b0, 32'h8000_0000);
        push_req(1'b0, 32'hffff_ffff);
        push_req(1'b0, 32'h0000_0000);
        push_req(1'b0, 32'h0000_0005);
        push_req(1'b0, 32'h0000_0005);
        push_req(1'b0, 32'h0000_0005);
        for (int i = 0; i < 9; i++)
            push_req(1'b0, 32'h0000_0100 + 32'(i));
        push_req(1'b0, 32'h7fff_ffff);
        push_req(1'b0, 32'h7fff_ffff);
        for (int i = 0; i < 5; i++)
            push_req(1'b1, 32'hdead_beef);

        // Sender idles less than the receiver; hold off once until drained
        queue_random(325);
        wait_idle();
        queue_random(325);
        wait_idle();

        // Receiver idles less than the sender
        sender_idle_pct   = 56;
        receiver_idle_pct = 36;
        queue_random(650);
        wait_idle();

        // Full rate on both sides
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        queue_random(650);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: max_heap_priority_queue_core.f
src/mhpq_pkg.sv
src/mhpq_ram.sv
src/mhpq_engine.sv
src/max_heap_priority_queue_core.sv
tb/testbench.sv
